@@ src/trig_series_evaluator_top_macros.svh @@
// Assertion helpers shared by the evaluator. Every check is sampled on the
// rising clock edge and is switched off while reset is held.
`ifndef TRIG_SERIES_EVALUATOR_TOP_MACROS_SVH
`define TRIG_SERIES_EVALUATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tse_pkg.sv @@
package tse_pkg;

    // Series size and the number of coefficient pairs held in registers.
    localparam int HARMONICS_DEF = 3;
    localparam int COEF_PAIRS    = 3;

    // Port widths.
    localparam int X_W        = 32;
    localparam int COEF_W     = 32;
    localparam int DIV_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_COEF_0    = 3'd0,
        CFG_COS_COEF_1    = 3'd1,
        CFG_COS_COEF_2    = 3'd2,
        CFG_SIN_COEF_0    = 3'd3,
        CFG_SIN_COEF_1    = 3'd4,
        CFG_SIN_COEF_2    = 3'd5,
        CFG_ANGLE_DIVISOR = 3'd6
    } cfg_reg_t;

    // Phase generation: |x*k| times turns per unit, then divided by the divisor.
    localparam int MAG_W      = 33;
    localparam int TURN_W     = 46;
    localparam logic [TURN_W-1:0] TURN_PER_UNIT = 46'd44798133900177;
    localparam int TURN_LO_W  = 23;
    localparam int TURN_HI_W  = TURN_W - TURN_LO_W;
    localparam logic [TURN_LO_W-1:0] TURN_LO = TURN_PER_UNIT[TURN_LO_W-1:0];
    localparam logic [TURN_HI_W-1:0] TURN_HI = TURN_PER_UNIT[TURN_W-1:TURN_LO_W];
    localparam int NUM_W      = MAG_W + TURN_W;
    localparam int PHASE_W    = 64;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PHASE_LAT  = 3 + DIV_STAGES;

    // Sine and cosine in Q24.
    localparam int TRIG_W   = 26;
    localparam int TRIG_LAT = 13;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 26'sd16777216;

    // Accumulation.
    localparam int PROD_W    = COEF_W + TRIG_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int PIPE_LAT  = 1 + PHASE_LAT + TRIG_LAT + 2;

endpackage

@@ src/trig_series_evaluator_top.sv @@
// Truncated Fourier series evaluator: for each point x (signed Q16.16) it
// returns the sum over the harmonics of cos_coef_k*cos(x*k/d) + sin_coef_k*
// sin(x*k/d), rounded to Q16.16 and saturated, with m_saturated flagging a
// clipped sum. A new point is taken every cycle unless the pipeline halts.
// The depth is set by the phase generator, thirteen stages whose larger part
// is the 79-bit division of the scaled point by the angle divisor at eight
// quotient bits per stage, and by the thirteen stages of the sine and cosine
// polynomials. The pipeline halts only when its last stage holds a result
// and the output register is still waiting to be taken. The user must write
// registers through cfg_we, cfg_index and cfg_wdata only while no transaction
// is in flight; the block does not enforce it. A divisor of zero acts as one.
`include "trig_series_evaluator_top_macros.svh"

module trig_series_evaluator_top #(
    parameter int HARMONICS = tse_pkg::HARMONICS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tse_pkg::X_W-1:0]      s_point,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tse_pkg::X_W-1:0]      m_value,
    output logic                                m_saturated,
    input  logic                                cfg_we,
    input  logic [tse_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tse_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import tse_pkg::*;

    localparam int NH    = (HARMONICS < COEF_PAIRS) ? HARMONICS : COEF_PAIRS;
    localparam int RND_W = ACC_W + 1 - 24;
    localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W+1)'(1) << 23;

    logic signed [COEF_W-1:0] cos_coef_reg [COEF_PAIRS];
    logic signed [COEF_W-1:0] sin_coef_reg [COEF_PAIRS];
    logic [DIV_W-1:0]         divisor_reg;
    logic [DIV_W-1:0]         divisor_eff;

    logic                     en;
    logic [PIPE_LAT-1:0]      vld_reg;
    logic signed [X_W-1:0]    x_reg;
    logic signed [TRIG_W-1:0] sn_w [COEF_PAIRS];
    logic signed [TRIG_W-1:0] cs_w [COEF_PAIRS];
    logic signed [PROD_W-1:0] cprod_reg [COEF_PAIRS];
    logic signed [PROD_W-1:0] sprod_reg [COEF_PAIRS];
    logic signed [ACC_W-1:0]  acc_c;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W:0]    biased_c;
    logic signed [RND_W-1:0]  rnd_c;
    logic                     sat_hi_c, sat_lo_c;

    logic                     m_valid_reg;
    logic signed [X_W-1:0]    m_value_reg;
    logic                     m_saturated_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < COEF_PAIRS; k++) begin
                cos_coef_reg[k] <= '0;
                sin_coef_reg[k] <= '0;
            end
            divisor_reg <= DIV_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_COS_COEF_0:    cos_coef_reg[0] <= cfg_wdata;
                CFG_COS_COEF_1:    cos_coef_reg[1] <= cfg_wdata;
                CFG_COS_COEF_2:    cos_coef_reg[2] <= cfg_wdata;
                CFG_SIN_COEF_0:    sin_coef_reg[0] <= cfg_wdata;
                CFG_SIN_COEF_1:    sin_coef_reg[1] <= cfg_wdata;
                CFG_SIN_COEF_2:    sin_coef_reg[2] <= cfg_wdata;
                CFG_ANGLE_DIVISOR: divisor_reg     <= cfg_wdata[DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign divisor_eff = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;

    // The whole pipeline moves unless its last stage is blocked by a full
    // output register.
    assign en      = !(vld_reg[PIPE_LAT-1] && m_valid_reg && !m_ready);
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= s_point;
        end
    end

    // One phase generator and one sine/cosine unit per live harmonic.
    // Harmonic zero has a fixed angle of zero.
    for (genvar k = 0; k < COEF_PAIRS; k++) begin : g_harm
        if (k == 0) begin : g_dc
            assign cs_w[k] = TRIG_ONE;
            assign sn_w[k] = '0;
        end else if (k < NH) begin : g_live
            logic [PHASE_W-1:0] phase;

            tse_phase #(
                .K (k)
            ) u_phase (
                .aclk    (aclk),
                .en      (en),
                .x       (x_reg),
                .divisor (divisor_eff),
                .phase   (phase)
            );

            tse_trig u_trig (
                .aclk  (aclk),
                .en    (en),
                .phase (phase),
                .sn    (sn_w[k]),
                .cs    (cs_w[k])
            );
        end else begin : g_off
            assign cs_w[k] = '0;
            assign sn_w[k] = '0;
        end
    end

    // Weighting by the coefficients.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < COEF_PAIRS; k++) begin
                cprod_reg[k] <= PROD_W'(cos_coef_reg[k]) * PROD_W'(cs_w[k]);
                sprod_reg[k] <= PROD_W'(sin_coef_reg[k]) * PROD_W'(sn_w[k]);
            end
        end
    end

    // Sum of all weighted terms.
    always_comb begin
        acc_c = '0;
        for (int k = 0; k < COEF_PAIRS; k++) begin
            acc_c = acc_c + ACC_W'(cprod_reg[k]) + ACC_W'(sprod_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= acc_c;
        end
    end

    // Round half up from Q40 to Q16 and saturate to 32 bits.
    always_comb begin
        biased_c = (ACC_W+1)'(acc_reg) + ROUND_HALF;
        rnd_c    = RND_W'(biased_c >>> 24);
        sat_hi_c = !rnd_c[RND_W-1] && (|rnd_c[RND_W-2:X_W-1]);
        sat_lo_c = rnd_c[RND_W-1] && !(&rnd_c[RND_W-2:X_W-1]);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && vld_reg[PIPE_LAT-1]) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vld_reg[PIPE_LAT-1]) begin
            priority if (sat_hi_c) begin
                m_value_reg <= {1'b0, {(X_W-1){1'b1}}};
            end else if (sat_lo_c) begin
                m_value_reg <= {1'b1, {(X_W-1){1'b0}}};
            end else begin
                m_value_reg <= rnd_c[X_W-1:0];
            end
            m_saturated_reg <= sat_hi_c || sat_lo_c;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_saturated = m_saturated_reg;

    // A clipped result sits at one of the two range limits.
    `TSE_ASSERT_NOW(a_sat_limit, m_valid && m_saturated, m_value == 32'sh7fff_ffff || m_value == 32'sh8000_0000, "saturated result is not at a range limit")
    // A stalled pipeline keeps every transaction in its place.
    `TSE_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_reg), "valid bits moved while stalled")
    // A transaction leaving the last stage lands in the output register.
    `TSE_ASSERT_NEXT(a_drain_lands, en && vld_reg[PIPE_LAT-1], m_valid, "result lost at output")

endmodule

@@ src/tse_phase.sv @@
module tse_phase #(
    parameter int K = 1
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [tse_pkg::X_W-1:0]   x,
    input  logic [tse_pkg::DIV_W-1:0]        divisor,
    output logic [tse_pkg::PHASE_W-1:0]      phase
);
    import tse_pkg::*;

    localparam int P_W  = X_W + 2;
    localparam int LO_W = MAG_W + TURN_LO_W;
    localparam int HI_W = MAG_W + TURN_HI_W;

    logic signed [P_W-1:0] prod_c;
    logic [MAG_W-1:0]      mag_c;
    logic                  mag_neg_c;

    logic [MAG_W-1:0] mag1_reg;
    logic             neg1_reg;
    logic [LO_W-1:0]  plo2_reg;
    logic [HI_W-1:0]  phi2_reg;
    logic             neg2_reg;
    logic [NUM_W-1:0] num3_reg;
    logic             neg3_reg;

    logic [DIV_W-1:0] rem_reg  [DIV_STAGES];
    logic [NUM_W-1:0] work_reg [DIV_STAGES];
    logic             dneg_reg [DIV_STAGES];

    // Harmonic scaling and magnitude. A negative product is handled as
    // its one's complement so that the floor division needs no correction.
    always_comb begin
        prod_c    = P_W'(x) * P_W'(K);
        mag_neg_c = prod_c[P_W-1];
        mag_c     = mag_neg_c ? MAG_W'(-prod_c) : MAG_W'(prod_c);
    end

    // Product with the turn constant in two halves, then the combine.
    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg <= mag_c;
            neg1_reg <= mag_neg_c;
            plo2_reg <= LO_W'(mag1_reg) * LO_W'(TURN_LO);
            phi2_reg <= HI_W'(mag1_reg) * HI_W'(TURN_HI);
            neg2_reg <= neg1_reg;
            num3_reg <= NUM_W'(plo2_reg) + (NUM_W'(phi2_reg) << TURN_LO_W)
                        - NUM_W'(neg2_reg);
            neg3_reg <= neg2_reg;
        end
    end

    // Restoring division by the divisor, a fixed number of quotient bits
    // per stage. The dividend shifts out at the top as quotient bits enter.
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        logic [DIV_W-1:0] rem_in;
        logic [NUM_W-1:0] work_in;
        logic             neg_in;
        logic [DIV_W-1:0] rem_c;
        logic [NUM_W-1:0] work_c;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign work_in = num3_reg;
            assign neg_in  = neg3_reg;
        end else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign work_in = work_reg[s-1];
            assign neg_in  = dneg_reg[s-1];
        end

        always_comb begin
            logic [DIV_W:0] trial;
            trial  = '0;
            rem_c  = rem_in;
            work_c = work_in;
            for (int i = 0; i < DIV_STEPS; i++) begin
                if (s * DIV_STEPS + i < NUM_W) begin
                    trial  = {rem_c, work_c[NUM_W-1]};
                    work_c = {work_c[NUM_W-2:0], 1'b0};
                    if (trial >= {1'b0, divisor}) begin
                        rem_c     = DIV_W'(trial - {1'b0, divisor});
                        work_c[0] = 1'b1;
                    end else begin
                        rem_c = trial[DIV_W-1:0];
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_c;
                work_reg[s] <= work_c;
                dneg_reg[s] <= neg_in;
            end
        end
    end

    // Low bits of the quotient are the phase in turns scaled by 2^64.
    assign phase = work_reg[DIV_STAGES-1][PHASE_W-1:0]
                 ^ {PHASE_W{dneg_reg[DIV_STAGES-1]}};

endmodule

@@ src/tse_trig.sv @@
module tse_trig (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [tse_pkg::PHASE_W-1:0]        phase,
    output logic signed [tse_pkg::TRIG_W-1:0]  sn,
    output logic signed [tse_pkg::TRIG_W-1:0]  cs
);
    import tse_pkg::*;

    localparam int ANG_W   = 30;
    localparam int T_W     = 31;
    localparam int MH_W    = 33;
    localparam int AP_W    = 65;
    localparam int RM_W    = 60;
    localparam int FP_W    = 61;
    localparam int V_W     = 25;
    localparam int CTL_N   = 10;
    localparam logic [31:0]      TWO_PI_Q29 = 32'd3373259426;
    localparam logic [T_W-1:0]   ONE_Q30    = 31'h4000_0000;
    localparam logic [ANG_W-1:0] RECIP_42   = 30'((64'd1 << 32) / 42);
    localparam logic [ANG_W-1:0] RECIP_20   = 30'((64'd1 << 32) / 20);
    localparam logic [ANG_W-1:0] RECIP_6    = 30'((64'd1 << 32) / 6);
    localparam logic [ANG_W-1:0] RECIP_56   = 30'((64'd1 << 32) / 56);
    localparam logic [ANG_W-1:0] RECIP_30   = 30'((64'd1 << 32) / 30);
    localparam logic [ANG_W-1:0] RECIP_12   = 30'((64'd1 << 32) / 12);
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [1:0]       quad;
        logic             neg;
        logic [ANG_W-1:0] ang;
        logic [ANG_W-1:0] ang_sq;
    } trig_ctl_t;

    // Estimate from the reciprocal is low by at most one; fix it up.
    function automatic logic [ANG_W-1:0] div_fix(input logic [ANG_W-1:0] num,
                                                 input logic [ANG_W-1:0] est,
                                                 input logic [5:0] dvs);
        logic [ANG_W+6:0] rem;
        rem = (ANG_W+7)'(num) - (ANG_W+7)'(est) * (ANG_W+7)'(dvs);
        return (rem >= (ANG_W+7)'(dvs)) ? ANG_W'(est + 1'b1) : est;
    endfunction

    // Reciprocal multiply, keeping the top bits.
    function automatic logic [ANG_W-1:0] recip_mul(input logic [ANG_W-1:0] num,
                                                   input logic [ANG_W-1:0] rcp);
        logic [RM_W-1:0] prod;
        prod = RM_W'(num) * RM_W'(rcp);
        return ANG_W'(prod >> 32);
    endfunction

    logic [PHASE_W-1:0] u_c;
    logic [61:0]        m_c;
    logic               neg_c;
    logic [ANG_W-1:0]   a_c;
    logic [ANG_W-1:0]   a2_c;
    logic [AP_W-1:0]    round_c;

    logic [1:0]      quad1_reg, quad2_reg;
    logic            neg1_reg, neg2_reg;
    logic [MH_W-1:0] mh1_reg;
    logic [AP_W-1:0] prod2_reg;
    trig_ctl_t       ctl_reg [CTL_N];

    logic [ANG_W-1:0] s_est1_reg, s_m3_reg, s_est4_reg, s_m4_reg, s_m6_reg;
    logic [ANG_W-1:0] s_est7_reg, s_m7_reg;
    logic [T_W-1:0]   s_t2_reg, s_t5_reg, s_t8_reg;
    logic [FP_W-1:0]  s_p9_reg;
    logic [ANG_W-1:0] c_est1_reg, c_m3_reg, c_est4_reg, c_m4_reg, c_m6_reg;
    logic [ANG_W-1:0] c_est7_reg, c_m7_reg;
    logic [T_W-1:0]   c_t2_reg, c_t5_reg, c_t8_reg;
    logic [FP_W-1:0]  c_p9_reg;

    logic [ANG_W-1:0]        s_val;
    logic [T_W-1:0]          c_val;
    logic [V_W-1:0]          sv, cv;
    logic signed [TRIG_W-1:0] sv_s, cv_s;

    // Octant reduction: quadrant and the magnitude of the remaining angle.
    always_comb begin
        u_c   = phase + (64'd1 << 61);
        neg_c = !u_c[61];
        if (neg_c) begin
            m_c = (62'd1 << 61) - {1'b0, u_c[60:0]};
        end else begin
            m_c = {1'b0, u_c[60:0]};
        end
    end

    // Angle in Q30 radians, rounded, and its square.
    always_comb begin
        round_c = prod2_reg + (AP_W'(1) << 33);
        a_c     = ANG_W'(round_c >> 34);
        a2_c    = ANG_W'((RM_W'(a_c) * RM_W'(a_c)) >> 30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad1_reg  <= u_c[63:62];
            neg1_reg   <= neg_c;
            mh1_reg    <= m_c[61:29];
            quad2_reg  <= quad1_reg;
            neg2_reg   <= neg1_reg;
            prod2_reg  <= AP_W'(mh1_reg) * AP_W'(TWO_PI_Q29);
            ctl_reg[0] <= '{quad: quad2_reg, neg: neg2_reg, ang: a_c, ang_sq: a2_c};
            for (int i = 1; i < CTL_N; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Horner evaluation of the sine and cosine series, one multiply per stage.
    always_ff @(posedge aclk) begin
        if (en) begin
            s_est1_reg <= recip_mul(ctl_reg[0].ang_sq, RECIP_42);
            s_t2_reg   <= ONE_Q30 - T_W'(div_fix(ctl_reg[1].ang_sq, s_est1_reg, 6'd42));
            s_m3_reg   <= ANG_W'((FP_W'(ctl_reg[2].ang_sq) * FP_W'(s_t2_reg)) >> 30);
            s_est4_reg <= recip_mul(s_m3_reg, RECIP_20);
            s_m4_reg   <= s_m3_reg;
            s_t5_reg   <= ONE_Q30 - T_W'(div_fix(s_m4_reg, s_est4_reg, 6'd20));
            s_m6_reg   <= ANG_W'((FP_W'(ctl_reg[5].ang_sq) * FP_W'(s_t5_reg)) >> 30);
            s_est7_reg <= recip_mul(s_m6_reg, RECIP_6);
            s_m7_reg   <= s_m6_reg;
            s_t8_reg   <= ONE_Q30 - T_W'(div_fix(s_m7_reg, s_est7_reg, 6'd6));
            s_p9_reg   <= FP_W'(ctl_reg[8].ang) * FP_W'(s_t8_reg);

            c_est1_reg <= recip_mul(ctl_reg[0].ang_sq, RECIP_56);
            c_t2_reg   <= ONE_Q30 - T_W'(div_fix(ctl_reg[1].ang_sq, c_est1_reg, 6'd56));
            c_m3_reg   <= ANG_W'((FP_W'(ctl_reg[2].ang_sq) * FP_W'(c_t2_reg)) >> 30);
            c_est4_reg <= recip_mul(c_m3_reg, RECIP_30);
            c_m4_reg   <= c_m3_reg;
            c_t5_reg   <= ONE_Q30 - T_W'(div_fix(c_m4_reg, c_est4_reg, 6'd30));
            c_m6_reg   <= ANG_W'((FP_W'(ctl_reg[5].ang_sq) * FP_W'(c_t5_reg)) >> 30);
            c_est7_reg <= recip_mul(c_m6_reg, RECIP_12);
            c_m7_reg   <= c_m6_reg;
            c_t8_reg   <= ONE_Q30 - T_W'(div_fix(c_m7_reg, c_est7_reg, 6'd12));
            c_p9_reg   <= FP_W'(ctl_reg[8].ang_sq) * FP_W'(c_t8_reg);
        end
    end

    // Round to Q24 and fold the quadrant back in.
    always_comb begin
        s_val = ANG_W'(s_p9_reg >> 30);
        c_val = ONE_Q30 - T_W'(c_p9_reg >> 31);
        sv    = V_W'((32'(s_val) + 32'd32) >> 6);
        cv    = V_W'((32'(c_val) + 32'd32) >> 6);
        sv_s  = ctl_reg[9].neg ? -TRIG_W'(sv) : TRIG_W'(sv);
        cv_s  = TRIG_W'(cv);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (ctl_reg[9].quad)
                QUAD_0: begin
                    sn <= sv_s;
                    cs <= cv_s;
                end
                QUAD_1: begin
                    sn <= cv_s;
                    cs <= -sv_s;
                end
                QUAD_2: begin
                    sn <= -sv_s;
                    cs <= -cv_s;
                end
                QUAD_3: begin
                    sn <= -cv_s;
                    cs <= sv_s;
                end
                default: begin
                    sn <= sv_s;
                    cs <= cv_s;
                end
            endcase
        end
    end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    import tse_pkg::*;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = PIPE_LAT + 10;

    localparam longint unsigned TURN_UNIT = 64'd44798133900177;
    localparam longint unsigned TWO_PI_29 = 64'd3373259426;
    localparam longint unsigned ONE_30    = 64'd1073741824;
    localparam longint unsigned HALF_TURN = 64'h2000000000000000;
    localparam longint unsigned RES_MASK  = 64'h3FFFFFFFFFFFFFFF;

    typedef struct {
        logic signed [X_W-1:0] value;
        logic                  saturated;
    } series_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [X_W-1:0]       s_point;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [X_W-1:0]       m_value;
    logic                        m_saturated;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_wdata;

    // Shadow copy of the register file.
    logic signed [COEF_W-1:0]    cos_w [COEF_PAIRS];
    logic signed [COEF_W-1:0]    sin_w [COEF_PAIRS];
    logic [DIV_W-1:0]            div_w;

    series_result_t              pending_sums [$];
    int                          errors = 0;
    int                          hold_off = 0;
    bit                          no_gaps = 0;

    trig_series_evaluator_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point     (s_point),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_saturated (m_saturated),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Sine and cosine in Q24 of a phase given as a fraction of a turn times 2^64.
    task automatic sin_cos_q24(input longint unsigned phase, output longint sn,
                               output longint cs);
        longint unsigned u, m, a, a2, t, s, c;
        longint res, sv, cv;
        bit neg;
        int quad;
        u = phase + HALF_TURN;
        quad = int'(u >> 62);
        res = longint'(u & RES_MASK) - longint'(HALF_TURN);
        neg = res < 0;
        m = neg ? longint'(-res) : res;
        a = ((m >> 29) * TWO_PI_29 + (64'd1 << 33)) >> 34;
        a2 = (a * a) >> 30;
        t = ONE_30 - a2 / 64'd42;
        t = ONE_30 - ((a2 * t) >> 30) / 64'd20;
        t = ONE_30 - ((a2 * t) >> 30) / 64'd6;
        s = (a * t) >> 30;
        t = ONE_30 - a2 / 64'd56;
        t = ONE_30 - ((a2 * t) >> 30) / 64'd30;
        t = ONE_30 - ((a2 * t) >> 30) / 64'd12;
        c = ONE_30 - ((a2 * t) >> 30) / 64'd2;
        sv = longint'((s + 64'd32) >> 6);
        cv = longint'((c + 64'd32) >> 6);
        if (neg) sv = -sv;
        case (quad)
            0: begin sn = sv;  cs = cv;  end
            1: begin sn = cv;  cs = -sv; end
            2: begin sn = -sv; cs = -cv; end
            default: begin sn = -cv; cs = sv; end
        endcase
    endtask

    // Series sum at one point under the shadow registers.
    task automatic predict_series_sum(input logic signed [X_W-1:0] x,
                                      output series_result_t res);
        longint xl, d, p, q, r, acc, v, sn, cs;
        longint unsigned phase;
        xl = x;
        d = (div_w == 0) ? 1 : longint'({48'd0, div_w});
        acc = 0;
        for (int k = 0; k < HARMONICS_DEF && k < COEF_PAIRS; k++) begin
            p = xl * k;
            q = p / d;
            r = p % d;
            if (r < 0) begin
                r += d;
                q -= 1;
            end
            phase = longint'(q) * TURN_UNIT + (longint'(r) * TURN_UNIT) / d;
            sin_cos_q24(phase, sn, cs);
            acc += longint'(cos_w[k]) * cs + longint'(sin_w[k]) * sn;
        end
        // Round half up from Q40 to Q16.
        v = (acc + (64'sd1 <<< 23)) >>> 24;
        res.saturated = 1'b0;
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            res.saturated = 1'b1;
        end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            res.saturated = 1'b1;
        end
        res.value = v[31:0];
    endtask

    // Register writes; the caller lowers the write enable after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        if (idx == CFG_COS_COEF_0) cos_w[0] = data;
        else if (idx == CFG_COS_COEF_1) cos_w[1] = data;
        else if (idx == CFG_COS_COEF_2) cos_w[2] = data;
        else if (idx == CFG_SIN_COEF_0) sin_w[0] = data;
        else if (idx == CFG_SIN_COEF_1) sin_w[1] = data;
        else if (idx == CFG_SIN_COEF_2) sin_w[2] = data;
        else if (idx == CFG_ANGLE_DIVISOR) div_w = data[DIV_W-1:0];
    endtask

    task automatic load_series(input logic [31:0] c0, c1, c2, s0, s1, s2,
                               input logic [31:0] divisor);
        write_reg(CFG_COS_COEF_0, c0);
        write_reg(CFG_COS_COEF_1, c1);
        write_reg(CFG_COS_COEF_2, c2);
        write_reg(CFG_SIN_COEF_0, s0);
        write_reg(CFG_SIN_COEF_1, s1);
        write_reg(CFG_SIN_COEF_2, s2);
        write_reg(CFG_ANGLE_DIVISOR, divisor);
        cfg_we <= 1'b0;
    endtask

    // Offer one point and record its expected sum once it is taken.
    task automatic send_point(input logic signed [X_W-1:0] x);
        int gap;
        series_result_t res;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_point <= x;
        do @(posedge aclk); while (!s_ready);
        predict_series_sum(x, res);
        pending_sums.push_back(res);
    endtask

    // Stop offering and wait until every outstanding transaction is back.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [X_W-1:0] random_point();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
            2: return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
            default: return $urandom & 32'h8007FFFF;
        endcase
    endfunction

    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 4))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
        endcase
    endfunction

    // Result side: random stalls, optional long hold-off, and the comparison.
    initial begin
        int stall;
        series_result_t exp_res;
        stall = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_sums.size() == 0) begin
                    $display("%0t: unexpected result value=%h sat=%b",
                             $time, m_value, m_saturated);
                    errors++;
                end else begin
                    exp_res = pending_sums.pop_front();
                    if (m_value !== exp_res.value) begin
                        $display("%0t: value expected %h actual %h",
                                 $time, exp_res.value, m_value);
                        errors++;
                    end
                    if (m_saturated !== exp_res.saturated) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, exp_res.saturated, m_saturated);
                        errors++;
                    end
                end
                stall = no_gaps ? 0 : $urandom_range(0, 3);
            end
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Corner points with simple weights, zero divisor and the unused index.
    task automatic test_directed();
        logic signed [X_W-1:0] pts [] = '{32'sh0, 32'sh7FFFFFFF, 32'sh80000000,
            -32'sh1, 32'sh1, 32'sh10000, -32'sh10000, 32'sh3243F, 32'sh1921F,
            32'sh6487F, -32'sh3243F, 32'sh4B65F, 32'sh0C90F};
        load_series(32'h10000, 32'h20000, 32'hFFFF0000, 32'h7FFFFFFF,
                    32'h18000, 32'h8000, 32'd1);
        foreach (pts[i]) send_point(pts[i]);
        drain();
        write_reg(CFG_UNUSED, 32'hFFFFFFFF);
        write_reg(CFG_ANGLE_DIVISOR, 32'd0);
        cfg_we <= 1'b0;
        foreach (pts[i]) send_point(pts[i]);
        drain();
        write_reg(CFG_ANGLE_DIVISOR, 32'hFFFFFFFF);
        cfg_we <= 1'b0;
        send_point(32'sh7FFFFFFF);
        send_point(32'sh80000000);
        drain();
    endtask

    // Extreme weights drive the sum past both ends of the range.
    task automatic test_saturation();
        load_series(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'd1);
        repeat (20) send_point(random_point());
        send_point(32'sh0);
        drain();
        load_series(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'd65535);
        repeat (20) send_point(random_point());
        send_point(32'sh0);
        drain();
    endtask

    // Receiver holds off while points keep coming, so the pipeline backs up.
    task automatic test_backpressure();
        no_gaps = 1;
        hold_off = 150;
        repeat (80) send_point(random_point());
        drain();
        no_gaps = 0;
    endtask

    // Many random settings, including stretches without any idling.
    task automatic test_random();
        logic [31:0] divisor;
        for (int phase_no = 0; phase_no < 32; phase_no++) begin
            case ($urandom_range(0, 3))
                0: divisor = 32'd1;
                1: divisor = 32'd65535;
                2: divisor = $urandom_range(1, 16);
                default: divisor = $urandom;
            endcase
            load_series(random_coef(), random_coef(), random_coef(),
                        random_coef(), random_coef(), random_coef(), divisor);
            no_gaps = (phase_no % 5 == 4);
            repeat (50) send_point(random_point());
            drain();
        end
        no_gaps = 0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_point = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cos_w = '{default: '0};
        sin_w = '{default: '0};
        div_w = 16'd1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Reset weights are all zero, so every sum must be zero.
        send_point(32'sh12345678);
        drain();
        test_directed();
        test_saturation();
        test_backpressure();
        test_random();
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/tse_pkg.sv
src/tse_phase.sv
src/tse_trig.sv
src/trig_series_evaluator_top.sv
dv/tb_top.sv
